// File: rtl/core/u16550_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16550_pkg
// Shared types, command and register codes, and bit constants for the
// 16550-style uart register block.
// ----------------------------------------------------------------------------
package u16550_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 16;

    typedef logic [1:0] cmd_t;
    typedef logic [2:0] reg_idx_t;
    typedef logic [7:0] byte_t;

    // item commands
    localparam cmd_t CMD_READ    = 2'd0;
    localparam cmd_t CMD_WRITE   = 2'd1;
    localparam cmd_t CMD_LINE_RX = 2'd2;
    localparam cmd_t CMD_TX_DONE = 2'd3;

    // register map
    localparam reg_idx_t REG_RBR_THR = 3'd0;
    localparam reg_idx_t REG_IER     = 3'd1;
    localparam reg_idx_t REG_IIR_FCR = 3'd2;
    localparam reg_idx_t REG_LCR     = 3'd3;
    localparam reg_idx_t REG_MCR     = 3'd4;
    localparam reg_idx_t REG_LSR     = 3'd5;
    localparam reg_idx_t REG_MSR     = 3'd6;
    localparam reg_idx_t REG_SCR     = 3'd7;

    localparam int LCR_DLAB_BIT   = 7;
    localparam int FCR_ENABLE_BIT = 0;
    localparam int FCR_CLR_RX_BIT = 1;
    localparam int FCR_CLR_TX_BIT = 2;
    localparam int IER_RX_BIT     = 0;
    localparam int MCR_DTR_BIT    = 0;
    localparam int MCR_RTS_BIT    = 1;

    localparam byte_t LSR_DR       = 8'h01;
    localparam byte_t LSR_OE       = 8'h02;
    localparam byte_t LSR_TX_EMPTY = 8'h20;
    localparam byte_t LSR_TX_IDLE  = 8'h40;
    localparam byte_t IIR_RX_DATA  = 8'h04;
    localparam byte_t IIR_NONE     = 8'h01;
    localparam byte_t IIR_FIFO_ON  = 8'hC0;

    typedef struct packed {
        cmd_t     command;
        reg_idx_t reg_index;
        byte_t    write_data;
        byte_t    line_byte;
    } item_t;

    typedef struct packed {
        byte_t       read_data;
        logic        tx_valid;
        byte_t       tx_byte;
        logic        irq;
        logic        dtr;
        logic        rts;
        logic [15:0] divisor;
    } result_t;

endpackage

// File: rtl/core/u16550_fifo_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16550_fifo_mem
// FIFO byte storage: one write port, one registered read port, with a
// same-cycle write-to-read bypass so the head byte is always current.
// ----------------------------------------------------------------------------
module u16550_fifo_mem #(
    parameter int DEPTH = 16,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_q_reg;
    logic [7:0] byp_data_reg;
    logic       byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg     <= mem[rd_addr];
        byp_data_reg <= wr_data;
    end

    // the read above sees the old entry when it is written in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_q_reg;

endmodule

// File: rtl/core/u16550_regfile.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16550_regfile
// Register state, FIFO pointers and the single-step update logic for one
// item; produces the result for the item being processed.
// ----------------------------------------------------------------------------
module u16550_regfile #(
    parameter int FIFO_DEPTH = u16550_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  u16550_pkg::item_t   item,
    output u16550_pkg::result_t result
);

    import u16550_pkg::*;

    localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(FIFO_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);

    logic [CNT_W-1:0] rx_count_reg, rx_count_next;
    logic [IDX_W-1:0] rx_head_reg, rx_head_next;
    logic [CNT_W-1:0] tx_count_reg, tx_count_next;
    logic [IDX_W-1:0] tx_head_reg, tx_head_next;
    logic [3:0]       int_enable_reg, int_enable_next;
    logic [7:0]       line_ctrl_reg, line_ctrl_next;
    logic [4:0]       modem_ctrl_reg, modem_ctrl_next;
    logic [7:0]       div_low_reg, div_low_next;
    logic [7:0]       div_high_reg, div_high_next;
    logic             fifo_on_reg, fifo_on_next;
    logic             busy_reg, busy_next;
    logic             overrun_reg, overrun_next;
    logic [7:0]       scratch_reg, scratch_next;

    logic             rx_wr_en, tx_wr_en;
    logic [IDX_W-1:0] rx_tail, tx_tail;
    logic [7:0]       rx_head_data, tx_head_data;
    logic [CNT_W-1:0] cur_depth;
    logic             dlab;
    logic             fcr_en;

    function automatic logic [IDX_W-1:0] ptr_add(input logic [IDX_W-1:0] p,
                                                 input logic [CNT_W-1:0] c);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(c);
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[IDX_W-1:0];
    endfunction

    assign dlab      = line_ctrl_reg[LCR_DLAB_BIT];
    assign cur_depth = fifo_on_reg ? DEPTH_C : CNT_W'(1);
    assign rx_tail   = ptr_add(rx_head_reg, rx_count_reg);
    assign tx_tail   = ptr_add(tx_head_reg, tx_count_reg);
    assign fcr_en    = item.write_data[FCR_ENABLE_BIT];

    u16550_fifo_mem #(.DEPTH(FIFO_DEPTH), .IDX_W(IDX_W)) u_rx_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_tail),
        .wr_data (item.line_byte),
        .rd_addr (rx_head_next),
        .rd_data (rx_head_data)
    );

    u16550_fifo_mem #(.DEPTH(FIFO_DEPTH), .IDX_W(IDX_W)) u_tx_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_tail),
        .wr_data (item.write_data),
        .rd_addr (tx_head_next),
        .rd_data (tx_head_data)
    );

    always_comb
    begin
        rx_count_next   = rx_count_reg;
        rx_head_next    = rx_head_reg;
        tx_count_next   = tx_count_reg;
        tx_head_next    = tx_head_reg;
        int_enable_next = int_enable_reg;
        line_ctrl_next  = line_ctrl_reg;
        modem_ctrl_next = modem_ctrl_reg;
        div_low_next    = div_low_reg;
        div_high_next   = div_high_reg;
        fifo_on_next    = fifo_on_reg;
        busy_next       = busy_reg;
        overrun_next    = overrun_reg;
        scratch_next    = scratch_reg;
        rx_wr_en        = 1'b0;
        tx_wr_en        = 1'b0;
        result          = '0;

        if (go)
        begin
            unique case (item.command)
                CMD_READ:
                begin
                    unique case (item.reg_index)
                        REG_RBR_THR:
                        begin
                            if (dlab)
                            begin
                                result.read_data = div_low_reg;
                            end
                            else if (rx_count_reg != '0)
                            begin
                                result.read_data = rx_head_data;
                                rx_head_next     = ptr_add(rx_head_reg, CNT_W'(1));
                                rx_count_next    = rx_count_reg - CNT_W'(1);
                            end
                        end
                        REG_IER:
                        begin
                            result.read_data = dlab ? div_high_reg : {4'b0, int_enable_reg};
                        end
                        REG_IIR_FCR:
                        begin
                            result.read_data =
                                ((int_enable_reg[IER_RX_BIT] && rx_count_reg != '0)
                                    ? IIR_RX_DATA : IIR_NONE)
                                | (fifo_on_reg ? IIR_FIFO_ON : 8'h00);
                        end
                        REG_LCR:
                        begin
                            result.read_data = line_ctrl_reg;
                        end
                        REG_MCR:
                        begin
                            result.read_data = {3'b0, modem_ctrl_reg};
                        end
                        REG_LSR:
                        begin
                            result.read_data =
                                ((rx_count_reg != '0) ? LSR_DR : 8'h00)
                                | (overrun_reg ? LSR_OE : 8'h00)
                                | ((tx_count_reg == '0) ? LSR_TX_EMPTY : 8'h00)
                                | ((tx_count_reg == '0 && !busy_reg) ? LSR_TX_IDLE : 8'h00);
                            overrun_next = 1'b0;
                        end
                        REG_MSR:
                        begin
                            result.read_data = 8'h00;
                        end
                        REG_SCR:
                        begin
                            result.read_data = scratch_reg;
                        end
                        default:
                        begin
                            result.read_data = 8'h00;
                        end
                    endcase
                end
                CMD_WRITE:
                begin
                    unique case (item.reg_index)
                        REG_RBR_THR:
                        begin
                            if (dlab)
                            begin
                                div_low_next = item.write_data;
                            end
                            else if (tx_count_reg < cur_depth)
                            begin
                                tx_wr_en      = 1'b1;
                                tx_count_next = tx_count_reg + CNT_W'(1);
                            end
                        end
                        REG_IER:
                        begin
                            if (dlab)
                            begin
                                div_high_next = item.write_data;
                            end
                            else
                            begin
                                int_enable_next = item.write_data[3:0];
                            end
                        end
                        REG_IIR_FCR:
                        begin
                            // toggling the enable bit flushes both fifos
                            if (fcr_en != fifo_on_reg || item.write_data[FCR_CLR_RX_BIT])
                            begin
                                rx_count_next = '0;
                                rx_head_next  = '0;
                            end
                            if (fcr_en != fifo_on_reg || item.write_data[FCR_CLR_TX_BIT])
                            begin
                                tx_count_next = '0;
                                tx_head_next  = '0;
                            end
                            fifo_on_next = fcr_en;
                        end
                        REG_LCR:
                        begin
                            line_ctrl_next = item.write_data;
                        end
                        REG_MCR:
                        begin
                            modem_ctrl_next = item.write_data[4:0];
                        end
                        REG_SCR:
                        begin
                            scratch_next = item.write_data;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                CMD_LINE_RX:
                begin
                    if (rx_count_reg >= cur_depth)
                    begin
                        overrun_next = 1'b1;
                    end
                    else
                    begin
                        rx_wr_en      = 1'b1;
                        rx_count_next = rx_count_reg + CNT_W'(1);
                    end
                end
                CMD_TX_DONE:
                begin
                    busy_next = 1'b0;
                end
                default:
                begin
                end
            endcase

            // load the shifter when idle; a byte written into an empty fifo
            // goes straight through
            if (!busy_next && tx_count_next != '0)
            begin
                result.tx_valid = 1'b1;
                result.tx_byte  = (tx_count_reg == '0) ? item.write_data : tx_head_data;
                tx_head_next    = ptr_add(tx_head_next, CNT_W'(1));
                tx_count_next   = tx_count_next - CNT_W'(1);
                busy_next       = 1'b1;
            end

            result.irq     = int_enable_next[IER_RX_BIT] && (rx_count_next != '0);
            result.dtr     = modem_ctrl_next[MCR_DTR_BIT];
            result.rts     = modem_ctrl_next[MCR_RTS_BIT];
            result.divisor = {div_high_next, div_low_next};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_count_reg   <= '0;
            rx_head_reg    <= '0;
            tx_count_reg   <= '0;
            tx_head_reg    <= '0;
            int_enable_reg <= '0;
            line_ctrl_reg  <= '0;
            modem_ctrl_reg <= '0;
            div_low_reg    <= '0;
            div_high_reg   <= '0;
            fifo_on_reg    <= 1'b0;
            busy_reg       <= 1'b0;
            overrun_reg    <= 1'b0;
            scratch_reg    <= '0;
        end
        else
        begin
            rx_count_reg   <= rx_count_next;
            rx_head_reg    <= rx_head_next;
            tx_count_reg   <= tx_count_next;
            tx_head_reg    <= tx_head_next;
            int_enable_reg <= int_enable_next;
            line_ctrl_reg  <= line_ctrl_next;
            modem_ctrl_reg <= modem_ctrl_next;
            div_low_reg    <= div_low_next;
            div_high_reg   <= div_high_next;
            fifo_on_reg    <= fifo_on_next;
            busy_reg       <= busy_next;
            overrun_reg    <= overrun_next;
            scratch_reg    <= scratch_next;
        end
    end

endmodule

// File: rtl/core/uart_16550_register_block_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_16550_register_block_top
// 16550-style uart register file with receive and transmit fifos.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid / in_stall carries one item: a bus read or write
//   of registers 0-7, a byte received from the line, or transmit shift done.
//   output channel out_valid / out_stall returns one result per item: read
//   data, a byte loaded into the transmit shifter (tx_valid, tx_byte), irq,
//   dtr, rts and the baud divisor, all as they stand after the item.
//   An accepted item is held in the input register; its whole update is
//   done there and its result is captured in the output register.
//   Throughput is one item per clock while out_stall is low; the register and
//   fifo pointer update is a single combinational step. The fifo head byte
//   comes from a registered read port that is addressed with the next head
//   pointer. When the receiver stalls, the output register holds its result
//   and one more item waits in the input register; after that in_stall goes
//   high. Reset clears all uart registers, fifo counts, pointers and both
//   channels; fifo byte storage is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module uart_16550_register_block_top #(
    parameter int FIFO_DEPTH = u16550_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [7:0]  line_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        irq,
    output logic        dtr,
    output logic        rts,
    output logic [15:0] divisor
);

    import u16550_pkg::*;

    item_t   item_reg;
    logic    in_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    advance;
    logic    go;
    logic    accept;

    assign advance  = !out_valid_reg || !out_stall;
    assign go       = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    u16550_regfile #(.FIFO_DEPTH(FIFO_DEPTH)) u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (go),
        .item   (item_reg),
        .result (result_next)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{command: command, reg_index: reg_index,
                          write_data: write_data, line_byte: line_byte};
        end
        if (go)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= go;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = result_reg.read_data;
    assign tx_valid  = result_reg.tx_valid;
    assign tx_byte   = result_reg.tx_byte;
    assign irq       = result_reg.irq;
    assign dtr       = result_reg.dtr;
    assign rts       = result_reg.rts;
    assign divisor   = result_reg.divisor;

endmodule

// File: rtl/core/u16550_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u16550_checker
// Port-level checks of the uart register block, bound to the top level.
// ----------------------------------------------------------------------------
module u16550_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  read_data,
    input logic        tx_valid,
    input logic [7:0]  tx_byte,
    input logic        irq,
    input logic [15:0] divisor
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable(read_data) && $stable(tx_valid) && $stable(tx_byte)
            && $stable(irq) && $stable(divisor))
        else $error("result changed while stalled");

    // the input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // no shifter load means no transmit byte
    a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> tx_byte == 8'h00)
        else $error("tx_byte set without tx_valid");

    // an input item held back in a stall cycle keeps out_valid high next cycle
    a_in_order: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> out_valid)
        else $error("result register emptied while input stalled");

endmodule

bind uart_16550_register_block_top u16550_checker u_chk (.*);

// File: tb/sv/uart_16550_register_block_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_16550_register_block_top_tb
// Sends bus reads and writes, line bytes and shift-done events into the uart
// register block. The input arrives in bursts and the output stalls in
// several patterns. A short table of directed items runs first, followed by
// random traffic grouped into phases. An in-bench model of the register file
// predicts each result the table does not give; each is compared field by field.
// ----------------------------------------------------------------------------
module uart_16550_register_block_top_tb;
    import u16550_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int DEPTH        = FIFO_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1500;
    localparam int PHASE_LEN    = 40;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {MIX_NOISE, RX_FLOOD, TX_FLOOD, DRAIN_ALL, REG_SETUP} traffic_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_t;

    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  command;
    logic [2:0]  reg_index;
    logic [7:0]  write_data;
    logic [7:0]  line_byte;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
    logic        dtr;
    logic        rts;
    logic [15:0] divisor;

    // uart register file as the bench sees it
    byte_t      rx_mem [DEPTH];
    byte_t      tx_mem [DEPTH];
    int         rx_cnt   = 0;
    int         rx_hd    = 0;
    int         tx_cnt   = 0;
    int         tx_hd    = 0;
    logic [3:0] ier_q    = '0;
    byte_t      lcr_q    = '0;
    logic [4:0] mcr_q    = '0;
    byte_t      dll_q    = '0;
    byte_t      dlm_q    = '0;
    byte_t      scr_q    = '0;
    bit         fifo_en  = 1'b0;
    bit         shifting = 1'b0;
    bit         overrun  = 1'b0;

    result_t    pending_results [$];
    dir_row_t   dir_rows [$];

    int         error_count     = 0;
    int         items_sent      = 0;
    int         results_checked = 0;
    int         tx_loads        = 0;
    int         tx_drops        = 0;
    int         rx_overruns     = 0;
    int         max_rx_fill     = 0;
    int         burst_left      = 0;
    int         stall_left      = 0;
    int         cycle_cnt       = 0;
    int         idle_cycles     = 0;
    stall_t     stall_mode      = STALL_NONE;

    uart_16550_register_block_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .reg_index  (reg_index),
        .write_data (write_data),
        .line_byte  (line_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .irq        (irq),
        .dtr        (dtr),
        .rts        (rts),
        .divisor    (divisor)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // advances the register file by one item and returns what the block must show
    function automatic result_t predict_uart(item_t it);
        result_t r;
        int      lim;
        bit      dlab;
        bit      en;
        byte_t   v;
        r    = '0;
        lim  = fifo_en ? DEPTH : 1;
        dlab = lcr_q[LCR_DLAB_BIT];
        case (it.command)
            CMD_READ:
                case (it.reg_index)
                    REG_RBR_THR:
                        if (dlab)
                            r.read_data = dll_q;
                        else if (rx_cnt > 0)
                        begin
                            r.read_data = rx_mem[rx_hd];
                            rx_hd = (rx_hd + 1) % DEPTH;
                            rx_cnt--;
                        end
                    REG_IER:
                        r.read_data = dlab ? dlm_q : {4'b0, ier_q};
                    REG_IIR_FCR:
                    begin
                        v = (ier_q[IER_RX_BIT] && rx_cnt > 0) ? IIR_RX_DATA : IIR_NONE;
                        if (fifo_en)
                            v = v | IIR_FIFO_ON;
                        r.read_data = v;
                    end
                    REG_LCR:
                        r.read_data = lcr_q;
                    REG_MCR:
                        r.read_data = {3'b0, mcr_q};
                    REG_LSR:
                    begin
                        v = '0;
                        if (rx_cnt > 0)
                            v = v | LSR_DR;
                        if (overrun)
                            v = v | LSR_OE;
                        if (tx_cnt == 0)
                            v = v | LSR_TX_EMPTY;
                        if (tx_cnt == 0 && !shifting)
                            v = v | LSR_TX_IDLE;
                        overrun = 1'b0;
                        r.read_data = v;
                    end
                    REG_SCR:
                        r.read_data = scr_q;
                    default:
                        r.read_data = '0;
                endcase
            CMD_WRITE:
                case (it.reg_index)
                    REG_RBR_THR:
                        if (dlab)
                            dll_q = it.write_data;
                        else if (tx_cnt < lim)
                        begin
                            tx_mem[(tx_hd + tx_cnt) % DEPTH] = it.write_data;
                            tx_cnt++;
                        end
                        else
                            tx_drops++;
                    REG_IER:
                        if (dlab)
                            dlm_q = it.write_data;
                        else
                            ier_q = it.write_data[3:0];
                    REG_IIR_FCR:
                    begin
                        en = it.write_data[FCR_ENABLE_BIT];
                        if (en != fifo_en || it.write_data[FCR_CLR_RX_BIT])
                        begin
                            rx_cnt = 0;
                            rx_hd  = 0;
                        end
                        if (en != fifo_en || it.write_data[FCR_CLR_TX_BIT])
                        begin
                            tx_cnt = 0;
                            tx_hd  = 0;
                        end
                        fifo_en = en;
                    end
                    REG_LCR:
                        lcr_q = it.write_data;
                    REG_MCR:
                        mcr_q = it.write_data[4:0];
                    REG_SCR:
                        scr_q = it.write_data;
                    default:
                        ;
                endcase
            CMD_LINE_RX:
                if (rx_cnt >= lim)
                begin
                    overrun = 1'b1;
                    rx_overruns++;
                end
                else
                begin
                    rx_mem[(rx_hd + rx_cnt) % DEPTH] = it.line_byte;
                    rx_cnt++;
                    if (rx_cnt > max_rx_fill)
                        max_rx_fill = rx_cnt;
                end
            default:
                shifting = 1'b0;
        endcase

        // idle shifter takes the oldest transmit byte at the end of every item
        if (!shifting && tx_cnt > 0)
        begin
            r.tx_valid = 1'b1;
            r.tx_byte  = tx_mem[tx_hd];
            tx_hd      = (tx_hd + 1) % DEPTH;
            tx_cnt--;
            shifting   = 1'b1;
            tx_loads++;
        end
        r.irq     = ier_q[IER_RX_BIT] && rx_cnt > 0;
        r.dtr     = mcr_q[MCR_DTR_BIT];
        r.rts     = mcr_q[MCR_RTS_BIT];
        r.divisor = {dlm_q, dll_q};
        return r;
    endfunction

    function automatic item_t make_item(cmd_t c, reg_idx_t r, byte_t wd, byte_t lb);
        item_t it;
        it.command    = c;
        it.reg_index  = r;
        it.write_data = wd;
        it.line_byte  = lb;
        return it;
    endfunction

    function automatic void add_row(cmd_t c, reg_idx_t r, byte_t wd, byte_t lb,
                                    bit typed = 1'b0, byte_t want_rd = '0,
                                    logic [15:0] want_div = '0);
        dir_row_t row;
        row.stim              = make_item(c, r, wd, lb);
        row.typed             = typed;
        row.want              = '0;
        row.want.read_data    = want_rd;
        row.want.divisor      = want_div;
        dir_rows.push_back(row);
    endfunction

    function automatic item_t random_item(traffic_t mode);
        item_t it;
        int    pick;
        it = make_item(CMD_READ, reg_idx_t'($urandom_range(0, 7)),
                       byte_t'($urandom), byte_t'($urandom));
        pick = $urandom_range(0, 99);
        case (mode)
            RX_FLOOD:
                if (pick < 70)
                    it.command = CMD_LINE_RX;
                else
                    it.reg_index = (pick < 80) ? REG_LSR : REG_RBR_THR;
            TX_FLOOD:
                if (pick < 70)
                begin
                    it.command   = CMD_WRITE;
                    it.reg_index = REG_RBR_THR;
                end
                else if (pick < 85)
                    it.command = CMD_TX_DONE;
                else
                    it.reg_index = REG_LSR;
            DRAIN_ALL:
                if (pick < 45)
                    it.reg_index = REG_RBR_THR;
                else if (pick < 75)
                    it.command = CMD_TX_DONE;
                else
                    it.reg_index = (pick < 88) ? REG_LSR : REG_IIR_FCR;
            REG_SETUP:
                if (pick < 55)
                    it.command = CMD_WRITE;
                else if (pick < 65)
                    it.command = CMD_LINE_RX;
            default:
                it.command = cmd_t'($urandom_range(0, 3));
        endcase
        return it;
    endfunction

    // bursty sender: random-length runs of back-to-back items, random gaps between
    task automatic send_item(item_t it, bit typed, result_t want);
        result_t predicted;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        burst_left--;
        in_valid   <= 1'b1;
        command    <= it.command;
        reg_index  <= it.reg_index;
        write_data <= it.write_data;
        line_byte  <= it.line_byte;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_uart(it);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endtask

    // result checker and receiver stall pattern
    always @(posedge clk)
    begin : result_check
        result_t exp_r;
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                         $time, read_data);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("read_data", exp_r.read_data, read_data);
                check_field("tx_valid", exp_r.tx_valid, tx_valid);
                check_field("tx_byte", exp_r.tx_byte, tx_byte);
                check_field("irq", exp_r.irq, irq);
                check_field("dtr", exp_r.dtr, dtr);
                check_field("rts", exp_r.rts, rts);
                check_field("divisor", exp_r.divisor, divisor);
                results_checked++;
            end
        end

        if (stall_left == 0)
        begin
            stall_mode = stall_t'($urandom_range(0, 3));
            stall_left = $urandom_range(50, 300);
        end
        stall_left--;
        cycle_cnt++;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: out_stall <= ((cycle_cnt % 7) < 3);
            default:        out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // no progress on either side for too long ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results still outstanding",
                     $time, pending_results.size());
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        traffic_t mode;
        byte_t    fcr_val;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        command    = CMD_READ;
        reg_index  = REG_RBR_THR;
        write_data = '0;
        line_byte  = '0;

        // state right after reset, divisor extremes through dlab
        add_row(CMD_READ,  REG_LSR,     8'h00, 8'h00, 1'b1, LSR_TX_EMPTY | LSR_TX_IDLE,
                16'h0000);
        add_row(CMD_READ,  REG_IIR_FCR, 8'h00, 8'h00, 1'b1, IIR_NONE, 16'h0000);
        add_row(CMD_READ,  REG_RBR_THR, 8'h00, 8'h00, 1'b1, 8'h00, 16'h0000);
        add_row(CMD_READ,  REG_MSR,     8'h00, 8'h00, 1'b1, 8'h00, 16'h0000);
        add_row(CMD_WRITE, REG_LCR,     8'h80, 8'h00, 1'b1, 8'h00, 16'h0000);
        add_row(CMD_WRITE, REG_RBR_THR, 8'hFF, 8'h00, 1'b1, 8'h00, 16'h00FF);
        add_row(CMD_WRITE, REG_IER,     8'hFF, 8'h00, 1'b1, 8'h00, 16'hFFFF);
        add_row(CMD_READ,  REG_RBR_THR, 8'h00, 8'h00, 1'b1, 8'hFF, 16'hFFFF);
        add_row(CMD_READ,  REG_IER,     8'h00, 8'h00, 1'b1, 8'hFF, 16'hFFFF);
        add_row(CMD_WRITE, REG_LCR,     8'h03, 8'h00);
        add_row(CMD_WRITE, REG_IER,     8'hFF, 8'h00);
        add_row(CMD_WRITE, REG_MCR,     8'hFF, 8'h00);
        add_row(CMD_WRITE, REG_SCR,     8'hA5, 8'h00);
        add_row(CMD_READ,  REG_SCR,     8'h00, 8'h00);
        // character mode: second line byte overruns
        add_row(CMD_LINE_RX, REG_RBR_THR, 8'h00, 8'h00);
        add_row(CMD_LINE_RX, REG_RBR_THR, 8'h00, 8'hFF);
        add_row(CMD_READ,  REG_IIR_FCR, 8'h00, 8'h00);
        add_row(CMD_READ,  REG_LSR,     8'h00, 8'h00);
        add_row(CMD_READ,  REG_RBR_THR, 8'h00, 8'h00);
        // one byte shifting, one held, third dropped
        add_row(CMD_WRITE, REG_RBR_THR, 8'h5A, 8'h00);
        add_row(CMD_WRITE, REG_RBR_THR, 8'hC3, 8'h00);
        add_row(CMD_WRITE, REG_RBR_THR, 8'h11, 8'h00);
        add_row(CMD_TX_DONE, REG_RBR_THR, 8'h00, 8'h00);
        add_row(CMD_TX_DONE, REG_RBR_THR, 8'h00, 8'h00);
        add_row(CMD_TX_DONE, REG_RBR_THR, 8'h00, 8'h00);
        add_row(CMD_WRITE, REG_IIR_FCR, 8'h07, 8'h00);
        add_row(CMD_WRITE, REG_LSR,     8'hFF, 8'h00);
        add_row(CMD_READ,  REG_IIR_FCR, 8'h00, 8'h00);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);

        mode = MIX_NOISE;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                // new phase: dlab off, fifos mostly on, clears now and then
                mode = traffic_t'($urandom_range(0, 4));
                fcr_val = byte_t'($urandom) & 8'hF8;
                if ($urandom_range(0, 3) != 0)
                    fcr_val[FCR_ENABLE_BIT] = 1'b1;
                if ($urandom_range(0, 7) == 0)
                begin
                    fcr_val[FCR_CLR_RX_BIT] = $urandom_range(0, 1);
                    fcr_val[FCR_CLR_TX_BIT] = $urandom_range(0, 1);
                end
                send_item(make_item(CMD_WRITE, REG_LCR, byte_t'($urandom_range(0, 127)),
                                    byte_t'($urandom)), 1'b0, '0);
                send_item(make_item(CMD_WRITE, REG_IIR_FCR, fcr_val, byte_t'($urandom)),
                          1'b0, '0);
            end
            send_item(random_item(mode), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d items, checked %0d results, %0d shifter loads, %0d tx writes dropped",
                 items_sent, results_checked, tx_loads, tx_drops);
        $display("receive fifo reached %0d of %0d entries, %0d line bytes lost to overrun",
                 max_rx_fill, DEPTH, rx_overruns);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
